// File: rtl/skl_pkg.sv
// shared types and constants for the sorted key list
`default_nettype none

package skl_pkg;

  localparam int KEY_W     = 64;
  localparam int KEY_BYTES = 8;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } stat_e;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LEFT,
    SEL_RIGHT
  } cell_sel_e;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

`default_nettype wire

// File: rtl/skl_if.sv
// request and response channel interfaces of the sorted key list
`default_nettype none

interface skl_req_if;
  import skl_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  modport source (output valid, output op, output key, input ready);
  modport sink (input valid, input op, input key, output ready);
endinterface

interface skl_rsp_if #(
  parameter int CNT_W = 5
);
  import skl_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic              found;
  logic [CNT_W-1:0]  position;
  logic [CNT_W-1:0]  entries_held;
  logic              empty_res;
  modport source (output valid, output status, output found, output position,
                  output entries_held, output empty_res, input ready);
  modport sink (input valid, input status, input found, input position,
                input entries_held, input empty_res, output ready);
endinterface

`default_nettype wire

// File: rtl/skl_cell.sv
// one storage cell of the key row: holds a key, compares it, moves it to a neighbor
`default_nettype none

module skl_cell (
  input  logic                            clk_i,
  input  skl_pkg::cell_sel_e              sel_i,
  input  logic                            cmp_en_i,
  input  logic [skl_pkg::KEY_W-1:0]       key_i,
  input  logic [skl_pkg::KEY_W-1:0]       left_i,
  input  logic [skl_pkg::KEY_W-1:0]       right_i,
  output logic [skl_pkg::KEY_W-1:0]       key_o,
  output skl_pkg::cell_flags_t            flags_o
);
  import skl_pkg::*;

  logic [KEY_W-1:0] key_q, key_d;
  cell_flags_t      flags_q, flags_d;

  always_comb begin
    case (sel_i)
      SEL_LOAD:  key_d = key_i;
      SEL_LEFT:  key_d = left_i;
      SEL_RIGHT: key_d = right_i;
      default:   key_d = key_q;
    endcase
  end

  always_comb begin
    flags_d = flags_q;
    if (cmp_en_i) begin
      flags_d.lt = key_q < key_i;
      flags_d.eq = key_q == key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    flags_q <= flags_d;
  end

  assign key_o   = key_q;
  assign flags_o = flags_q;

endmodule

`default_nettype wire

// File: rtl/skl_locate.sv
// finds the insert point and first match from the registered cell flags
`default_nettype none

module skl_locate #(
  parameter int DEPTH = 16,
  parameter int CNT_W = 5
) (
  input  skl_pkg::cell_flags_t flags_i [DEPTH],
  input  logic [CNT_W-1:0]     count_i,
  output logic [DEPTH-1:0]     below_o,
  output logic [DEPTH:0]       bound_o,
  output logic [CNT_W-1:0]     pos_o,
  output logic                 hit_o
);
  import skl_pkg::*;

  logic [DEPTH-1:0] used;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      used[i]    = CNT_W'(i) < count_i;
      below_o[i] = used[i] & flags_i[i].lt;
    end
  end

  // stored keys are sorted, so the below-key cells form a prefix
  always_comb begin
    bound_o[0] = ~below_o[0];
    for (int i = 1; i < DEPTH; i++) begin
      bound_o[i] = below_o[i-1] & ~below_o[i];
    end
    bound_o[DEPTH] = below_o[DEPTH-1];
  end

  always_comb begin
    pos_o = '0;
    hit_o = 1'b0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (bound_o[i]) pos_o = pos_o | CNT_W'(i);
    end
    for (int i = 0; i < DEPTH; i++) begin
      hit_o = hit_o | (bound_o[i] & used[i] & flags_i[i].eq);
    end
  end

endmodule

`default_nettype wire

// File: rtl/sorted_key_list.sv
// sorted key list: ordered key table with insert, search and remove
//
// req_i carries one transaction per operation: op (insert, search, remove;
// code 3 acts as search) and a 64-bit key, first character in the top byte.
// Only the top KEY_CHARS bytes of the key take part; the rest reads as zero.
// rsp_o returns exactly one transaction per request: status, found, position,
// entries_held and empty_res.
// In the accept cycle every cell of the key row compares its key with the new
// one and registers the result. In the apply state that follows, the insert
// point is located, the row shifts by one place for an insert into a table
// that is not full or for a remove that finds its key, and the response is
// loaded into the output register. A request is taken only in the idle state,
// so a new one is not accepted until the last one has been applied.
// If the receiver stalls, the response waits in the output register; the
// next request is still accepted and compared, and its shift is held until
// the waiting response is taken.
// Reset empties the table and drops any pending response; key cells are not
// cleared, since cells at or above the count never affect a result.
`default_nettype none

module sorted_key_list #(
  parameter int DEPTH     = 16,
  parameter int KEY_CHARS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  skl_req_if.sink          req_i,
  skl_rsp_if.source        rsp_o
);
  import skl_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} << (8 * (KEY_BYTES - KEY_CHARS));

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;

  logic              out_valid_q;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic              found_q;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]  held_q;

  logic              accept;
  logic              apply;
  logic [KEY_W-1:0]  cell_key;

  logic [KEY_W-1:0]  row_key [DEPTH];
  cell_flags_t       row_flags [DEPTH];
  cell_sel_e         row_sel [DEPTH];

  logic [DEPTH-1:0]  below;
  logic [DEPTH:0]    bound;
  logic [CNT_W-1:0]  loc_pos;
  logic              loc_hit;
  logic              full;
  logic              do_ins;
  logic              do_rem;

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_APPLY;
      ST_APPLY: if (apply) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    req_i.ready = 1'b0;
    apply       = 1'b0;
    case (state_q)
      ST_IDLE:  req_i.ready = 1'b1;
      ST_APPLY: apply = ~out_valid_q | rsp_o.ready;
      default:  ;
    endcase
  end

  assign accept   = req_i.valid & req_i.ready;
  assign cell_key = (state_q == ST_IDLE) ? (req_i.key & KEY_MASK) : key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_key, right_key;
    if (i == 0) begin : g_first
      assign left_key = row_key[i];
    end else begin : g_left
      assign left_key = row_key[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_key = row_key[i];
    end else begin : g_right
      assign right_key = row_key[i+1];
    end

    skl_cell u_cell (
      .clk_i    (clk_i),
      .sel_i    (row_sel[i]),
      .cmp_en_i (accept),
      .key_i    (cell_key),
      .left_i   (left_key),
      .right_i  (right_key),
      .key_o    (row_key[i]),
      .flags_o  (row_flags[i])
    );
  end

  skl_locate #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_locate (
    .flags_i (row_flags),
    .count_i (count_q),
    .below_o (below),
    .bound_o (bound),
    .pos_o   (loc_pos),
    .hit_o   (loc_hit)
  );

  assign full   = count_q == CNT_W'(DEPTH);
  assign do_ins = apply & (op_q == OP_INSERT) & ~full;
  assign do_rem = apply & (op_q == OP_REMOVE) & loc_hit;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      row_sel[i] = SEL_HOLD;
      if (do_ins) begin
        if (bound[i]) row_sel[i] = SEL_LOAD;
        else if (!below[i]) row_sel[i] = SEL_LEFT;
      end else if (do_rem) begin
        if (!below[i]) row_sel[i] = SEL_RIGHT;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) count_d = count_q + CNT_W'(1);
    else if (do_rem) count_d = count_q - CNT_W'(1);
  end

  always_comb begin
    stat_d = STAT_OK;
    pos_d  = loc_pos;
    if (op_q == OP_INSERT) begin
      if (full) stat_d = STAT_FULL;
    end else if (!loc_hit) begin
      stat_d = STAT_NOT_FOUND;
      pos_d  = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (apply) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.op;
      key_q <= req_i.key & KEY_MASK;
    end
    if (apply) begin
      stat_q  <= stat_d;
      found_q <= loc_hit;
      pos_q   <= pos_d;
      held_q  <= count_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = stat_q;
  assign rsp_o.found        = found_q;
  assign rsp_o.position     = pos_q;
  assign rsp_o.entries_held = held_q;
  assign rsp_o.empty_res    = held_q == '0;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_one_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> $onehot(bound))
    else $error("insert point not unique");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |-> !req_i.ready)
    else $error("request taken while a transaction is in flight");

  a_apply_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    apply |=> out_valid_q)
    else $error("applied transaction left no response");

endmodule

`default_nettype wire
